FILE: sv/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and helpers for the burning ship escape-time block.
// ----------------------------------------------------------------------------
package bse_pkg;

   // image geometry (powers of two, division by these is a shift)
   localparam int WIDTH        = 1024;
   localparam int HEIGHT       = 1024;
   localparam int WIDTH_SHIFT  = $clog2(WIDTH);
   localparam int HEIGHT_SHIFT = $clog2(HEIGHT);

   // default iteration limit
   localparam int MAX_ITER_DEF = 64;

   // fixed point format and field widths
   localparam int FRAC_BITS = 28;
   localparam int Q_W       = 32;
   localparam int ZOOM_W    = 31;
   localparam int PIX_W     = 10;
   localparam int STEP_W    = 6;
   localparam int SUM_W     = 38;
   localparam int PROD_W    = 2 * Q_W;
   localparam int CSR_IDX_W = 2;

   // escape bound: 4.0 in the squared (Q8.56) domain
   localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(4) << (2 * FRAC_BITS);

   // zoom reset value, 1.0
   localparam logic [ZOOM_W-1:0] ZOOM_RESET = ZOOM_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_x;
      logic [PIX_W-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]  pixel_x_out;
      logic [PIX_W-1:0]  pixel_y_out;
      logic              escaped;
      logic [STEP_W-1:0] escape_step;
   } rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZOOM        = 2'd0,
      CSR_OFFSET_REAL = 2'd1,
      CSR_OFFSET_IMAG = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [ZOOM_W-1:0]       zoom;
      logic signed [Q_W-1:0]   offset_real;
      logic signed [Q_W-1:0]   offset_imag;
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_ITER
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic map;
      logic step;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic esc_hit;
      logic at_limit;
   } status_type;

   // clamp a wide signed sum to the Q4.28 range
   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-Q_W:0] top;
      top = v[SUM_W-1:Q_W-1];
      if (top == '0 || top == '1) begin
         return v[Q_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         return {1'b0, {(Q_W-1){1'b1}}};
      end
   endfunction

endpackage

FILE: sv/bse_csr.sv
// ----------------------------------------------------------------------------
// bse_csr
// View registers: zoom and the two pan offsets, written through the csr port.
// ----------------------------------------------------------------------------
module bse_csr
   import bse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_data,
   output csr_type              csr_regs
);

   csr_type regs_ff;
   csr_type regs_in;

   // the port is always ready, so every write is accepted
   assign csr_ready = 1'b1;

   // register decode, unknown index is dropped
   always_comb begin
      regs_in = regs_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ZOOM:        regs_in.zoom        = csr_data[ZOOM_W-1:0];
            CSR_OFFSET_REAL: regs_in.offset_real = $signed(csr_data);
            CSR_OFFSET_IMAG: regs_in.offset_imag = $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.zoom        <= ZOOM_RESET;
         regs_ff.offset_real <= '0;
         regs_ff.offset_imag <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_regs = regs_ff;

endmodule

FILE: sv/bse_datapath.sv
// ----------------------------------------------------------------------------
// bse_datapath
// Pixel to point mapping, one burning ship step per cycle, escape test,
// step counter and the result register.
// ----------------------------------------------------------------------------
module bse_datapath
   import bse_pkg::*;
#(
   parameter int MAX_ITER = MAX_ITER_DEF
)
(
   input  logic       clock,
   input  cmd_type    cmd,
   input  req_type    req_data,
   input  csr_type    csr_regs,
   output status_type status,
   output rsp_type    rsp_data
);

   localparam int CNT_W = $clog2(MAX_ITER);
   localparam int MAPP_W = ZOOM_W + PIX_W + 2;

   logic [PIX_W-1:0]      px_ff, py_ff;
   logic signed [Q_W-1:0] cx_ff, cy_ff, zx_ff, zy_ff;
   logic [CNT_W-1:0]      cnt_ff;
   rsp_type               rsp_ff;

   // mapping signals
   logic [ZOOM_W+PIX_W-1:0] prod_x, prod_y;
   logic [MAPP_W-1:0]       tx_w, ty_w;
   logic signed [SUM_W-1:0] z2_s, offr_s, offi_s, tx_s, ty_s;
   logic signed [SUM_W-1:0] cx_sum, cy_sum;

   // iteration signals
   logic [Q_W-1:0]          mag_x, mag_y;
   logic [PROD_W-1:0]       prod_aa, prod_bb, prod_ab;
   logic signed [SUM_W-1:0] sa_s, sb_s, ab_s, cxe_s, cye_s;
   logic signed [SUM_W-1:0] nx_sum, ny_sum;
   logic [PROD_W:0]         mag_sum;
   logic                    esc;
   logic [CNT_W-1:0]        cnt_m1;
   logic [31:0]             step_wide;

   // linear map of the pixel onto the view
   always_comb begin
      prod_x = csr_regs.zoom * px_ff;
      prod_y = csr_regs.zoom * py_ff;
      tx_w   = {prod_x, 2'b00} >> WIDTH_SHIFT;
      ty_w   = {prod_y, 2'b00} >> HEIGHT_SHIFT;
      z2_s   = $signed({{(SUM_W-ZOOM_W-1){1'b0}}, csr_regs.zoom, 1'b0});
      offr_s = SUM_W'(csr_regs.offset_real);
      offi_s = SUM_W'(csr_regs.offset_imag);
      tx_s   = $signed({1'b0, tx_w[SUM_W-2:0]});
      ty_s   = $signed({1'b0, ty_w[SUM_W-2:0]});
      cx_sum = z2_s - offr_s - tx_s;
      cy_sum = ty_s - z2_s - offi_s;
   end

   // one step: square of |z| plus c, and the escape test on the current z
   always_comb begin
      mag_x   = zx_ff[Q_W-1] ? Q_W'(-zx_ff) : zx_ff;
      mag_y   = zy_ff[Q_W-1] ? Q_W'(-zy_ff) : zy_ff;
      prod_aa = mag_x * mag_x;
      prod_bb = mag_y * mag_y;
      prod_ab = mag_x * mag_y;
      sa_s    = $signed({2'b00, prod_aa[PROD_W-1:FRAC_BITS]});
      sb_s    = $signed({2'b00, prod_bb[PROD_W-1:FRAC_BITS]});
      ab_s    = $signed({1'b0, prod_ab[PROD_W-1:FRAC_BITS-1]});
      cxe_s   = SUM_W'(cx_ff);
      cye_s   = SUM_W'(cy_ff);
      nx_sum  = sa_s - sb_s + cxe_s;
      ny_sum  = ab_s + cye_s;
      mag_sum = {1'b0, prod_aa} + {1'b0, prod_bb};
      esc     = mag_sum > ESC_LIMIT;
   end

   // status back to the controller, z at count zero is the origin
   assign status.esc_hit  = esc && (cnt_ff != '0);
   assign status.at_limit = (cnt_ff == CNT_W'(MAX_ITER - 1));

   // index of the step that produced the current z
   assign cnt_m1    = cnt_ff - CNT_W'(1);
   assign step_wide = 32'(cnt_m1);

   // item capture, point setup and orbit update
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff <= req_data.pixel_x;
         py_ff <= req_data.pixel_y;
      end
      if (cmd.map) begin
         cx_ff  <= sat_q(cx_sum);
         cy_ff  <= sat_q(cy_sum);
         zx_ff  <= '0;
         zy_ff  <= '0;
         cnt_ff <= '0;
      end else if (cmd.step) begin
         zx_ff  <= sat_q(nx_sum);
         zy_ff  <= sat_q(ny_sum);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.pixel_x_out <= px_ff;
         rsp_ff.pixel_y_out <= py_ff;
         rsp_ff.escaped     <= status.esc_hit;
         rsp_ff.escape_step <= status.esc_hit ? step_wide[STEP_W-1:0] : '0;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/bse_ctrl.sv
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: takes an item, runs the map and iteration states, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module bse_ctrl
   import bse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish;
   logic      out_free;

   assign finish   = status.esc_hit || status.at_limit;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_ITER;
         end
         ST_ITER: begin
            if (finish && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands and handshake
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_MAP: begin
            cmd.map = 1'b1;
         end
         ST_ITER: begin
            cmd.step     = !finish;
            cmd.load_rsp = finish && out_free;
         end
         default: ;
      endcase
   end

   // output register occupancy
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/burning_ship_escape_time.sv
// ----------------------------------------------------------------------------
// burning_ship_escape_time
// Escape-time engine for the burning ship fractal, one pixel per item.
// ----------------------------------------------------------------------------
// Each item is a pixel position; it is mapped onto the view set by zoom and
// the two offsets (Q4.28) and iterated with z = (|Re z| + i|Im z|)^2 + c.
// The engine works on one item at a time. An item is accepted in the idle
// state and mapped from pixel to point in the map state; then it is iterated
// one orbit step per cycle in the iteration state on three 32x32 multipliers,
// with the escape test of the previous step's z done in the same cycle. A
// finished orbit waits in the iteration state while the previous result
// has not been taken yet. The result sits in an output register, so the
// next item is taken while it waits. Configuration writes are always
// accepted.
// ----------------------------------------------------------------------------
module burning_ship_escape_time
   import bse_pkg::*;
#(
   parameter int MAX_ITER = MAX_ITER_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [Q_W-1:0]       csr_data
);

   csr_type    csr_regs;
   cmd_type    cmd;
   status_type status;

   bse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_regs  (csr_regs)
   );

   bse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bse_datapath #(
      .MAX_ITER (MAX_ITER)
   ) u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_regs (csr_regs),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // a result is never loaded over one that has not been taken
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result loaded while output register busy");

   // a taken item blocks the input until its work is done
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after an item was taken");

   // a bounded orbit reports step zero
   a_step_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.escaped) |-> (rsp_data.escape_step == '0))
      else $error("nonzero step on a bounded orbit");

   // stepping and result load are exclusive
   a_step_or_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.step && cmd.load_rsp))
      else $error("orbit step and result load in the same cycle");

endmodule
